>>> src/dap_pkg.sv
package dap_pkg;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;

  // largest magnitude that may still take another digit
  localparam logic [63:0] MagQuot = 64'd922337203685477580;
  localparam logic [3:0]  PosRem  = 4'd7;
  localparam logic [3:0]  NegRem  = 4'd8;

  localparam logic [8:0] FracMax = 9'd256;
  localparam logic [1:0] DotMax  = 2'd2;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_PLUS      = 3'd1,
    ERR_EMPTY     = 3'd2,
    ERR_MULTI_DOT = 3'd3,
    ERR_MISSING   = 3'd4,
    ERR_PREC_LONG = 3'd5,
    ERR_NON_DIGIT = 3'd6,
    ERR_RANGE     = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    DIG_NONE      = 2'd0,
    DIG_NON_DIGIT = 2'd1,
    DIG_RANGE     = 2'd2
  } dig_err_t;

  typedef struct packed {
    logic [63:0] mag;
    logic [63:0] neg_mag;
    logic        is_negative;
    logic        at_first_char;
    logic        plus_seen;
    logic [1:0]  dot_count;
    logic        whole_seen;
    logic [8:0]  frac_len;
    dig_err_t    dig_err;
  } state_t;

  localparam state_t StateReset = '{
    mag:           64'd0,
    neg_mag:       64'd0,
    is_negative:   1'b0,
    at_first_char: 1'b1,
    plus_seen:     1'b0,
    dot_count:     2'd0,
    whole_seen:    1'b0,
    frac_len:      9'd0,
    dig_err:       DIG_NONE
  };

endpackage

>>> src/dap_if.sv
interface dap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface dap_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] amount;
  logic        [7:0]  precision;
  logic        [2:0]  error_code;

  modport source (output valid, output amount, output precision, output error_code,
                  input ready);
  modport sink (input valid, input amount, input precision, input error_code,
                output ready);
endinterface

>>> src/dap_step.sv
module dap_step (
  input  dap_pkg::state_t    state,
  input  logic [7:0]         char_code,
  output dap_pkg::state_t    state_next,
  output logic signed [63:0] amount,
  output logic [7:0]         precision,
  output dap_pkg::err_t      error_code
);

  logic        take;
  logic        char_is_num;
  logic [3:0]  digit;
  logic [3:0]  rem;
  logic        over;
  logic [63:0] mag_acc;
  logic [63:0] neg_acc;
  logic        neg_next;

  assign neg_next = state.at_first_char ? (char_code == dap_pkg::ChMinus) : state.is_negative;
  assign take = !state.at_first_char ||
                ((char_code != dap_pkg::ChPlus) && (char_code != dap_pkg::ChMinus));
  assign char_is_num = (char_code >= dap_pkg::ChZero) && (char_code <= dap_pkg::ChNine);
  assign digit = 4'(char_code - dap_pkg::ChZero);
  assign rem = neg_next ? dap_pkg::NegRem : dap_pkg::PosRem;
  assign over = (state.mag > dap_pkg::MagQuot) ||
                ((state.mag == dap_pkg::MagQuot) && (digit > rem));
  // times ten as shift-add, negated copy runs alongside
  assign mag_acc = (state.mag << 3) + (state.mag << 1) + 64'(digit);
  assign neg_acc = (state.neg_mag << 3) + (state.neg_mag << 1) - 64'(digit);

  always_comb begin
    state_next = state;
    state_next.at_first_char = 1'b0;
    state_next.is_negative = neg_next;
    if (state.at_first_char && (char_code == dap_pkg::ChPlus)) begin
      state_next.plus_seen = 1'b1;
    end
    if (take) begin
      if (char_code == dap_pkg::ChDot) begin
        if (state.dot_count != dap_pkg::DotMax) begin
          state_next.dot_count = state.dot_count + 2'd1;
        end
      end else begin
        if (state.dot_count == 2'd0) begin
          state_next.whole_seen = 1'b1;
        end else if (state.frac_len != dap_pkg::FracMax) begin
          state_next.frac_len = state.frac_len + 9'd1;
        end
        if (state.dig_err == dap_pkg::DIG_NONE) begin
          if (!char_is_num) begin
            state_next.dig_err = dap_pkg::DIG_NON_DIGIT;
          end else if (over) begin
            state_next.dig_err = dap_pkg::DIG_RANGE;
          end else begin
            state_next.mag = mag_acc;
            state_next.neg_mag = neg_acc;
          end
        end
      end
    end
  end

  always_comb begin
    priority if (state_next.plus_seen) begin
      error_code = dap_pkg::ERR_PLUS;
    end else if (state_next.is_negative && state_next.dot_count == 2'd0 &&
                 !state_next.whole_seen) begin
      error_code = dap_pkg::ERR_EMPTY;
    end else if (state_next.dot_count == dap_pkg::DotMax) begin
      error_code = dap_pkg::ERR_MULTI_DOT;
    end else if (state_next.dot_count == 2'd1 &&
                 (!state_next.whole_seen || state_next.frac_len == 9'd0)) begin
      error_code = dap_pkg::ERR_MISSING;
    end else if (state_next.dot_count == 2'd1 && state_next.frac_len[8]) begin
      error_code = dap_pkg::ERR_PREC_LONG;
    end else if (state_next.dig_err == dap_pkg::DIG_NON_DIGIT) begin
      error_code = dap_pkg::ERR_NON_DIGIT;
    end else if (state_next.dig_err == dap_pkg::DIG_RANGE) begin
      error_code = dap_pkg::ERR_RANGE;
    end else begin
      error_code = dap_pkg::ERR_OK;
    end
  end

  always_comb begin
    if (error_code == dap_pkg::ERR_OK) begin
      amount = state_next.is_negative ? state_next.neg_mag : state_next.mag;
      precision = state_next.frac_len[7:0];
    end else begin
      amount = 64'sd0;
      precision = 8'd0;
    end
  end

endmodule

>>> src/decimal_amount_parser.sv
// Parses a signed ASCII decimal amount arriving one character per word on din,
// the final character flagged by last, and delivers one word on dout holding the
// signed amount in smallest units, the count of fraction digits and an error
// code. A character is taken every cycle unless a final character is held in
// the input register for a busy output; it is registered, folded into the
// running state (times-ten accumulate with exact overflow check), and on the
// final character the result lands in the output register. Throughput is one
// character per cycle as long as dout is drained; an output word that waits
// blocks only the next final character.
module decimal_amount_parser (
  input logic       clk,
  input logic       rst,
  dap_in_if.sink    din,
  dap_out_if.source dout
);

  logic               s1_valid;
  logic [7:0]         s1_char;
  logic               s1_last;
  dap_pkg::state_t    state;
  dap_pkg::state_t    state_next;
  logic signed [63:0] res_amount;
  logic [7:0]         res_precision;
  dap_pkg::err_t      res_error;
  logic               out_valid;
  logic signed [63:0] out_amount;
  logic [7:0]         out_precision;
  logic [2:0]         out_error;
  logic               out_free;
  logic               s1_adv;

  dap_step u_step (
    .state      (state),
    .char_code  (s1_char),
    .state_next (state_next),
    .amount     (res_amount),
    .precision  (res_precision),
    .error_code (res_error)
  );

  assign out_free = !out_valid || dout.ready;
  assign s1_adv = s1_valid && (!s1_last || out_free);
  assign din.ready = !s1_valid || s1_adv;

  assign dout.valid = out_valid;
  assign dout.amount = out_amount;
  assign dout.precision = out_precision;
  assign dout.error_code = out_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      state <= dap_pkg::StateReset;
      out_valid <= 1'b0;
    end else begin
      if (din.ready) begin
        s1_valid <= din.valid;
      end
      if (s1_adv) begin
        state <= s1_last ? dap_pkg::StateReset : state_next;
      end
      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_char <= din.char_code;
      s1_last <= din.last;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_amount <= res_amount;
      out_precision <= res_precision;
      out_error <= res_error;
    end
  end

endmodule
